FILE: hdl/rge_pkg.sv
package rge_pkg;

   localparam int NUM_BITS  = 256;
   localparam int LOG_DEPTH = 1024;

   localparam int IDX_W  = 8;
   localparam int POS_W  = 10;
   localparam int CNT_W  = 32;
   localparam int BIT_AW = (NUM_BITS > 1) ? $clog2(NUM_BITS) : 1;
   localparam int LOG_AW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;

   // one sweep clears both stores, so it covers the deeper one
   localparam int CLR_DEPTH = (LOG_DEPTH > NUM_BITS) ? LOG_DEPTH : NUM_BITS;
   localparam int CLR_AW    = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;

   typedef enum logic [1:0] {
      REQ_EXEC       = 2'd0,
      REQ_CHECKPOINT = 2'd1,
      REQ_RESTORE    = 2'd2
   } req_kind_type;

   typedef enum logic [1:0] {
      GATE_CCNOT = 2'd0,
      GATE_CNOT  = 2'd1,
      GATE_NOT   = 2'd2,
      GATE_SWAP  = 2'd3
   } gate_code_type;

   // log entry layout: gate in 1:0, a in 9:2, b in 17:10, c in 25:18
   typedef struct packed {
      logic [IDX_W-1:0] c;
      logic [IDX_W-1:0] b;
      logic [IDX_W-1:0] a;
      gate_code_type    gate;
   } log_entry_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
      logic             val;
   } bit_write_type;

   typedef struct packed {
      bit_write_type w1;
      bit_write_type w2;
      logic          na;
      logic          nb;
      logic          nc;
      log_entry_type entry;
   } gate_result_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RDC,
      ST_GATE,
      ST_SWAP2,
      ST_LOGRD,
      ST_LOGDAT,
      ST_FIN_AB,
      ST_FIN_C,
      ST_FIN_CAP,
      ST_DONE
   } seq_state_type;

   function automatic logic idx_ok(input logic [IDX_W-1:0] idx);
      return ({1'b0, idx} < (IDX_W+1)'(NUM_BITS));
   endfunction

endpackage

FILE: hdl/reversible_gate_engine_with_undo_log.sv
// Channel   Direction  Handshake          Item fields
// req       in         req_valid/stall    type, gate_code, bit_a/b/c, restore_position
// rsp       out        rsp_valid/stall    head_position, op_count, value_a/b/c
//
// An execute reads a/b, reads c, then writes, and a SWAP adds a second write: the bit
// file has two read ports and one write port, so reads of a/b, the read of c and each
// write take a state of their own. A checkpoint reads back its bits. A restore to a valid
// position other than the head steps back one log entry at a time, undoing each gate.
// After reset a clearing pass over CLR_DEPTH (1024) addresses zeroes both memories;
// no item is taken until it ends. A stalled result holds in the output register
// while the next item runs; that item waits at its end for the register to free.
module reversible_gate_engine_with_undo_log import rge_pkg::*; (
   input  logic             clock,
   input  logic             reset,

   input  logic             req_valid,
   output logic             req_stall,
   input  logic [1:0]       req_type,
   input  logic [1:0]       req_gate_code,
   input  logic [IDX_W-1:0] req_bit_a,
   input  logic [IDX_W-1:0] req_bit_b,
   input  logic [IDX_W-1:0] req_bit_c,
   input  logic [POS_W-1:0] req_restore_position,

   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [POS_W-1:0] rsp_head_position,
   output logic [CNT_W-1:0] rsp_op_count,
   output logic             rsp_value_a,
   output logic             rsp_value_b,
   output logic             rsp_value_c
);

   seq_state_type     state_ff, state_in;
   logic [CLR_AW-1:0] clr_ff, clr_in;
   logic [LOG_AW-1:0] head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [LOG_AW-1:0] target_ff, target_in;
   logic              exec_ff, exec_in;
   logic [IDX_W-1:0]  req_a_ff, req_a_in;
   logic [IDX_W-1:0]  req_b_ff, req_b_in;
   logic [IDX_W-1:0]  req_c_ff, req_c_in;
   log_entry_type     op_ff, op_in;
   logic              ra_ff, ra_in;
   logic              rb_ff, rb_in;
   bit_write_type     w2_ff, w2_in;
   logic              out_a_ff, out_a_in;
   logic              out_b_ff, out_b_in;
   logic              out_c_ff, out_c_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]  rsp_head_ff;
   logic [CNT_W-1:0]  rsp_count_ff;
   logic              rsp_a_ff, rsp_b_ff, rsp_c_ff;
   logic              rsp_load;

   // memory ports
   bit_write_type     bit_wr;
   logic [IDX_W-1:0]  rd_idx0, rd_idx1;
   logic              rd_bit0, rd_bit1;
   logic              log_wr_en;
   logic [LOG_AW-1:0] log_wr_addr, log_rd_addr;
   log_entry_type     log_wr_data, log_rd_data;

   gate_result_type   res;
   logic [LOG_AW-1:0] head_inc, head_dec;
   logic              pos_ok;
   logic [LOG_AW-1:0] pos_tgt;
   logic              walk_end;

   rge_bit_ram u_bits (
      .clock   (clock),
      .wr      (bit_wr),
      .rd_idx0 (rd_idx0),
      .rd_idx1 (rd_idx1),
      .rd_bit0 (rd_bit0),
      .rd_bit1 (rd_bit1)
   );

   rge_log_ram u_log (
      .clock   (clock),
      .wr_en   (log_wr_en),
      .wr_addr (log_wr_addr),
      .wr_data (log_wr_data),
      .rd_addr (log_rd_addr),
      .rd_data (log_rd_data)
   );

   // c always arrives on read port 0 in the gate cycle
   rge_gate_alu u_alu (
      .op  (op_ff),
      .ra  (ra_ff),
      .rb  (rb_ff),
      .rc  (rd_bit0),
      .res (res)
   );

   // circular head arithmetic, any log depth
   assign head_inc = (head_ff == LOG_AW'(LOG_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign head_dec = (head_ff == '0) ? LOG_AW'(LOG_DEPTH - 1) : head_ff - 1'b1;

   // restore targets past the log are ignored
   assign pos_ok   = (32'(req_restore_position) < 32'(LOG_DEPTH));
   assign pos_tgt  = LOG_AW'(req_restore_position);
   assign walk_end = (head_ff == target_ff);

   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: no reset
   always_ff @(posedge clock) begin
      target_ff <= target_in;
      exec_ff   <= exec_in;
      req_a_ff  <= req_a_in;
      req_b_ff  <= req_b_in;
      req_c_ff  <= req_c_in;
      op_ff     <= op_in;
      ra_ff     <= ra_in;
      rb_ff     <= rb_in;
      w2_ff     <= w2_in;
      out_a_ff  <= out_a_in;
      out_b_ff  <= out_b_in;
      out_c_ff  <= out_c_in;
      if (rsp_load) begin
         rsp_head_ff  <= POS_W'(head_ff);
         rsp_count_ff <= count_ff;
         rsp_a_ff     <= out_a_ff;
         rsp_b_ff     <= out_b_ff;
         rsp_c_ff     <= out_c_ff;
      end
   end

   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      head_in     = head_ff;
      count_in    = count_ff;
      target_in   = target_ff;
      exec_in     = exec_ff;
      req_a_in    = req_a_ff;
      req_b_in    = req_b_ff;
      req_c_in    = req_c_ff;
      op_in       = op_ff;
      ra_in       = ra_ff;
      rb_in       = rb_ff;
      w2_in       = w2_ff;
      out_a_in    = out_a_ff;
      out_b_in    = out_b_ff;
      out_c_in    = out_c_ff;
      bit_wr      = '0;
      rd_idx0     = op_ff.c;
      rd_idx1     = op_ff.b;
      log_wr_en   = 1'b0;
      log_wr_addr = head_ff;
      log_wr_data = res.entry;
      log_rd_addr = head_dec;
      rsp_load    = 1'b0;

      unique case (state_ff)
         // zero one bit-file entry and one log entry per cycle
         ST_CLEAR: begin
            bit_wr      = '{en: 1'b1, idx: IDX_W'(clr_ff[BIT_AW-1:0]), val: 1'b0};
            log_wr_en   = 1'b1;
            log_wr_addr = clr_ff[LOG_AW-1:0];
            log_wr_data = '0;
            if (clr_ff == CLR_AW'(CLR_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end

         // take an item; start the a/b reads straight from the ports
         ST_IDLE: begin
            rd_idx0 = req_bit_a;
            rd_idx1 = req_bit_b;
            if (req_valid) begin
               req_a_in = req_bit_a;
               req_b_in = req_bit_b;
               req_c_in = req_bit_c;
               op_in    = '{c: req_bit_c, b: req_bit_b, a: req_bit_a,
                            gate: gate_code_type'(req_gate_code)};
               exec_in  = 1'b0;
               unique case (req_type)
                  REQ_EXEC: begin
                     exec_in  = 1'b1;
                     state_in = ST_RDC;
                  end
                  REQ_RESTORE: begin
                     if (pos_ok && (pos_tgt != head_ff)) begin
                        target_in = pos_tgt;
                        state_in  = ST_LOGRD;
                     end else begin
                        state_in = ST_FIN_C;
                     end
                  end
                  // checkpoint and the unused code only report
                  default: begin
                     state_in = ST_FIN_C;
                  end
               endcase
            end
         end

         // capture a/b, fetch c
         ST_RDC: begin
            ra_in    = rd_bit0;
            rb_in    = rd_bit1;
            rd_idx0  = op_ff.c;
            state_in = ST_GATE;
         end

         // apply the gate; an execute also logs it and advances the head
         ST_GATE: begin
            bit_wr = res.w1;
            w2_in  = res.w2;
            if (exec_ff) begin
               log_wr_en = 1'b1;
               head_in   = head_inc;
               count_in  = count_ff + 1'b1;
               out_a_in  = res.na;
               out_b_in  = res.nb;
               out_c_in  = res.nc;
            end
            if (op_ff.gate == GATE_SWAP) begin
               state_in = ST_SWAP2;
            end else if (exec_ff) begin
               state_in = ST_DONE;
            end else if (walk_end) begin
               state_in = ST_FIN_AB;
            end else begin
               state_in = ST_LOGRD;
            end
         end

         // second half of a SWAP
         ST_SWAP2: begin
            bit_wr = w2_ff;
            if (exec_ff) begin
               state_in = ST_DONE;
            end else if (walk_end) begin
               state_in = ST_FIN_AB;
            end else begin
               state_in = ST_LOGRD;
            end
         end

         // step the head back and fetch the entry it lands on
         ST_LOGRD: begin
            log_rd_addr = head_dec;
            head_in     = head_dec;
            count_in    = count_ff - 1'b1;
            state_in    = ST_LOGDAT;
         end

         // entry arrives: load it as the operation, read its a/b
         ST_LOGDAT: begin
            op_in    = log_rd_data;
            rd_idx0  = log_rd_data.a;
            rd_idx1  = log_rd_data.b;
            state_in = ST_RDC;
         end

         // walk finished: read back the requested bits
         ST_FIN_AB: begin
            rd_idx0  = req_a_ff;
            rd_idx1  = req_b_ff;
            state_in = ST_FIN_C;
         end

         ST_FIN_C: begin
            out_a_in = rd_bit0;
            out_b_in = rd_bit1;
            rd_idx0  = req_c_ff;
            state_in = ST_FIN_CAP;
         end

         ST_FIN_CAP: begin
            out_c_in = rd_bit0;
            state_in = ST_DONE;
         end

         // hold until the output register is free
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register: load a finished item, drop it once taken
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_head_position = rsp_head_ff;
   assign rsp_op_count      = rsp_count_ff;
   assign rsp_value_a       = rsp_a_ff;
   assign rsp_value_b       = rsp_b_ff;
   assign rsp_value_c       = rsp_c_ff;

endmodule

FILE: hdl/rge_bit_ram.sv
module rge_bit_ram import rge_pkg::*; (
   input  logic             clock,
   input  bit_write_type    wr,
   input  logic [IDX_W-1:0] rd_idx0,
   input  logic [IDX_W-1:0] rd_idx1,
   output logic             rd_bit0,
   output logic             rd_bit1
);

   logic bits_mem [NUM_BITS];
   logic data0_ff, data1_ff;
   logic ok0_ff, ok1_ff;

   // drop writes to indexes past the file
   always_ff @(posedge clock) begin
      if (wr.en && idx_ok(wr.idx)) begin
         bits_mem[wr.idx[BIT_AW-1:0]] <= wr.val;
      end
      data0_ff <= bits_mem[rd_idx0[BIT_AW-1:0]];
      data1_ff <= bits_mem[rd_idx1[BIT_AW-1:0]];
      ok0_ff   <= idx_ok(rd_idx0);
      ok1_ff   <= idx_ok(rd_idx1);
   end

   // indexes past the file read as zero
   assign rd_bit0 = data0_ff & ok0_ff;
   assign rd_bit1 = data1_ff & ok1_ff;

endmodule

FILE: hdl/rge_log_ram.sv
module rge_log_ram import rge_pkg::*; (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [LOG_AW-1:0] wr_addr,
   input  log_entry_type     wr_data,
   input  logic [LOG_AW-1:0] rd_addr,
   output log_entry_type     rd_data
);

   log_entry_type log_mem [LOG_DEPTH];
   log_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         log_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= log_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/rge_gate_alu.sv
module rge_gate_alu import rge_pkg::*; (
   input  log_entry_type   op,
   input  logic            ra,
   input  logic            rb,
   input  logic            rc,
   output gate_result_type res
);

   // value of one operand after both writes land, later write wins
   function automatic logic merge_bit(input logic [IDX_W-1:0] idx, input logic orig,
                                      input bit_write_type w1, input bit_write_type w2);
      logic v;
      v = orig;
      if (w1.en && (w1.idx == idx)) begin
         v = w1.val;
      end
      if (w2.en && (w2.idx == idx)) begin
         v = w2.val;
      end
      return v;
   endfunction

   always_comb begin
      res            = '0;
      res.entry.gate = op.gate;
      res.entry.a    = op.a;
      unique case (op.gate)
         GATE_CCNOT: begin
            res.w1      = '{en: ra & rb & idx_ok(op.c), idx: op.c, val: ~rc};
            res.entry.b = op.b;
            res.entry.c = op.c;
         end
         GATE_CNOT: begin
            res.w1      = '{en: ra & idx_ok(op.b), idx: op.b, val: ~rb};
            res.entry.b = op.b;
         end
         GATE_NOT: begin
            res.w1 = '{en: idx_ok(op.a), idx: op.a, val: ~ra};
         end
         GATE_SWAP: begin
            res.w1      = '{en: idx_ok(op.a), idx: op.a, val: rb};
            res.w2      = '{en: idx_ok(op.b), idx: op.b, val: ra};
            res.entry.b = op.b;
         end
      endcase
      res.na = merge_bit(op.a, ra, res.w1, res.w2);
      res.nb = merge_bit(op.b, rb, res.w1, res.w2);
      res.nc = merge_bit(op.c, rc, res.w1, res.w2);
   end

endmodule

FILE: hdl/rge_checker.sv
module rge_checker import rge_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic [1:0]       req_type,
   input logic [1:0]       req_gate_code,
   input logic [IDX_W-1:0] req_bit_a,
   input logic [IDX_W-1:0] req_bit_b,
   input logic [IDX_W-1:0] req_bit_c,
   input logic [POS_W-1:0] req_restore_position,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic [POS_W-1:0] rsp_head_position,
   input logic [CNT_W-1:0] rsp_op_count,
   input logic             rsp_value_a,
   input logic             rsp_value_b,
   input logic             rsp_value_c
);

   // a stalled request stays and does not change
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_type) && $stable(req_gate_code)
         && $stable(req_bit_a) && $stable(req_bit_b) && $stable(req_bit_c)
         && $stable(req_restore_position))
      else $error("request changed while stalled");

   // a stalled result stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // a stalled result does not change
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_head_position) && $stable(rsp_op_count)
         && $stable(rsp_value_a) && $stable(rsp_value_b) && $stable(rsp_value_c))
      else $error("result changed while stalled");

   // every item leaves the idle state on its accept, so the input closes after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input open right after an accept");

   // a new result only appears out of a busy cycle
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without an item in work");

endmodule

bind reversible_gate_engine_with_undo_log rge_checker u_rge_checker (.*);

FILE: dv/testbench.sv
module testbench;
   import rge_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // req_type has one code that the package leaves undefined; the block must only report
   localparam logic [1:0] REQ_UNDEFINED = 2'd3;

   // what one result item should carry
   typedef struct packed {
      logic [POS_W-1:0] head;
      logic [CNT_W-1:0] count;
      logic             va;
      logic             vb;
      logic             vc;
   } engine_result_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;

   logic             req_valid = 1'b0;
   logic             req_stall;
   logic [1:0]       req_type = '0;
   logic [1:0]       req_gate_code = '0;
   logic [IDX_W-1:0] req_bit_a = '0;
   logic [IDX_W-1:0] req_bit_b = '0;
   logic [IDX_W-1:0] req_bit_c = '0;
   logic [POS_W-1:0] req_restore_position = '0;

   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [POS_W-1:0] rsp_head_position;
   logic [CNT_W-1:0] rsp_op_count;
   logic             rsp_value_a;
   logic             rsp_value_b;
   logic             rsp_value_c;

   // shadow copy of the engine state, advanced once per accepted item
   logic             shadow_bits [NUM_BITS];
   log_entry_type    shadow_log  [LOG_DEPTH];
   logic [POS_W-1:0] shadow_head;
   logic [CNT_W-1:0] shadow_count;

   engine_result_type awaited_results [$];
   int               requests_sent = 0;
   int               error_count   = 0;
   bit               idle_enable   = 1'b1;

   reversible_gate_engine_with_undo_log u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_type             (req_type),
      .req_gate_code        (req_gate_code),
      .req_bit_a            (req_bit_a),
      .req_bit_b            (req_bit_b),
      .req_bit_c            (req_bit_c),
      .req_restore_position (req_restore_position),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_head_position    (rsp_head_position),
      .rsp_op_count         (rsp_op_count),
      .rsp_value_a          (rsp_value_a),
      .rsp_value_b          (rsp_value_b),
      .rsp_value_c          (rsp_value_c)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------------
   // Shadow model of the engine
   // ---------------------------------------------------------------------------------------

   function automatic void reset_shadow();
      foreach (shadow_bits[i]) shadow_bits[i] = 1'b0;
      foreach (shadow_log[i]) shadow_log[i] = '0;
      shadow_head  = '0;
      shadow_count = '0;
   endfunction

   // indexes past the end of the bit file read as zero and swallow writes
   function automatic logic shadow_read(input logic [IDX_W-1:0] idx);
      return (int'(idx) < NUM_BITS) ? shadow_bits[idx] : 1'b0;
   endfunction

   function automatic void shadow_write(input logic [IDX_W-1:0] idx, input logic val);
      if (int'(idx) < NUM_BITS) shadow_bits[idx] = val;
   endfunction

   function automatic void shadow_gate(input gate_code_type gate,
                                       input logic [IDX_W-1:0] a, b, c);
      logic held;
      case (gate)
         GATE_CCNOT: if (shadow_read(a) && shadow_read(b)) shadow_write(c, !shadow_read(c));
         GATE_CNOT:  if (shadow_read(a)) shadow_write(b, !shadow_read(b));
         GATE_NOT:   shadow_write(a, !shadow_read(a));
         default: begin
            held = shadow_read(a);
            shadow_write(a, shadow_read(b));
            shadow_write(b, held);
         end
      endcase
   endfunction

   // advance the shadow by one request and return the result it must produce
   function automatic engine_result_type predict_response(input logic [1:0] kind,
                                                          input gate_code_type gate,
                                                          input logic [IDX_W-1:0] a, b, c,
                                                          input logic [POS_W-1:0] pos);
      log_entry_type     entry;
      engine_result_type res;
      if (kind == REQ_EXEC) begin
         shadow_gate(gate, a, b, c);
         // unused operands are logged as zero
         entry.gate = gate;
         entry.a    = a;
         entry.b    = (gate == GATE_NOT) ? '0 : b;
         entry.c    = (gate == GATE_CCNOT) ? c : '0;
         shadow_log[shadow_head] = entry;
         shadow_head  = POS_W'((int'(shadow_head) + 1) % LOG_DEPTH);
         shadow_count = shadow_count + 1'b1;
      end else if (kind == REQ_RESTORE && int'(pos) < LOG_DEPTH) begin
         // step back one entry at a time, undoing each self-inverse gate
         while (shadow_head != pos) begin
            shadow_head = (shadow_head == '0) ? POS_W'(LOG_DEPTH - 1) : shadow_head - 1'b1;
            entry = shadow_log[shadow_head];
            shadow_gate(entry.gate, entry.a, entry.b, entry.c);
            shadow_count = shadow_count - 1'b1;
         end
      end
      res.head  = shadow_head;
      res.count = shadow_count;
      res.va    = shadow_read(a);
      res.vb    = shadow_read(b);
      res.vc    = shadow_read(c);
      return res;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Result side: random stall, and check every accepted result against the oldest one due
   // ---------------------------------------------------------------------------------------

   task automatic report_mismatch(input string what);
      error_count++;
      $display("%0t ns: mismatch: %s", $time, what);
   endtask

   task automatic check_result();
      engine_result_type want;
      if (awaited_results.size() == 0) begin
         report_mismatch("result item arrived with none awaited");
      end else begin
         want = awaited_results.pop_front();
         if (rsp_head_position !== want.head)
            report_mismatch($sformatf("head_position %0d, want %0d",
                                      rsp_head_position, want.head));
         if (rsp_op_count !== want.count)
            report_mismatch($sformatf("op_count 0x%08h, want 0x%08h", rsp_op_count, want.count));
         if (rsp_value_a !== want.va)
            report_mismatch($sformatf("value_a %b, want %b", rsp_value_a, want.va));
         if (rsp_value_b !== want.vb)
            report_mismatch($sformatf("value_b %b, want %b", rsp_value_b, want.vb));
         if (rsp_value_c !== want.vc)
            report_mismatch($sformatf("value_c %b, want %b", rsp_value_c, want.vc));
      end
   endtask

   // stall at random, with a chance of 31 in 100, unless idling is switched off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= idle_enable && ($urandom_range(0, 99) < 31);
      end
   end

   // values read here are the ones present at the edge, so this sees the handshake as the
   // block does
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) check_result();
   end

   // ---------------------------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------------------------

   // Present one item and hold it until accepted. Valid stays high on return so that a
   // following call in the same step can replace the payload without a low cycle; anything
   // that waits afterward must drop valid first.
   task automatic send_request(input logic [1:0] kind, input gate_code_type gate,
                               input logic [IDX_W-1:0] a, b, c,
                               input logic [POS_W-1:0] pos);
      while (idle_enable && $urandom_range(0, 99) < 31) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_type             <= kind;
      req_gate_code        <= gate;
      req_bit_a            <= a;
      req_bit_b            <= b;
      req_bit_c            <= c;
      req_restore_position <= pos;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      awaited_results.push_back(predict_response(kind, gate, a, b, c, pos));
      requests_sent++;
   endtask

   // fields that a request ignores get random values; an execute's unused operands come from the caller
   task automatic exec_gate(input gate_code_type gate, input logic [IDX_W-1:0] a, b, c);
      send_request(REQ_EXEC, gate, a, b, c, POS_W'($urandom));
   endtask

   task automatic take_checkpoint();
      send_request(REQ_CHECKPOINT, gate_code_type'($urandom_range(0, 3)), IDX_W'($urandom),
                   IDX_W'($urandom), IDX_W'($urandom), POS_W'($urandom));
   endtask

   task automatic restore_to(input logic [POS_W-1:0] pos);
      send_request(REQ_RESTORE, gate_code_type'($urandom_range(0, 3)), IDX_W'($urandom),
                   IDX_W'($urandom), IDX_W'($urandom), pos);
   endtask

   task automatic send_undefined();
      send_request(REQ_UNDEFINED, gate_code_type'($urandom_range(0, 3)), IDX_W'($urandom),
                   IDX_W'($urandom), IDX_W'($urandom), POS_W'($urandom));
   endtask

   // favor a few low indexes so gates hit each other's bits and controls are often set
   function automatic logic [IDX_W-1:0] pick_index();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return IDX_W'($urandom_range(0, 7));
      if (roll < 60) return IDX_W'(NUM_BITS - 1 - $urandom_range(0, 7));
      return IDX_W'($urandom);
   endfunction

   task automatic exec_random_gate();
      exec_gate(gate_code_type'($urandom_range(0, 3)), pick_index(), pick_index(), pick_index());
   endtask

   // drop valid and hold until every awaited result has come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_results.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------------

   // Field extremes, every gate and request kind, and the special cases, from a clean state.
   task automatic test_directed_cases();
      take_checkpoint();                         // head still zero
      exec_gate(GATE_NOT,   8'd0,   8'd0,   8'd0);
      exec_gate(GATE_NOT,   8'd255, 8'd0,   8'd0);
      exec_gate(GATE_CNOT,  8'd0,   8'd1,   8'd0);
      exec_gate(GATE_CCNOT, 8'd0,   8'd1,   8'd2);   // both controls set: target flips
      exec_gate(GATE_CCNOT, 8'd0,   8'd3,   8'd4);   // one control clear: nothing flips
      exec_gate(GATE_SWAP,  8'd2,   8'd254, 8'd0);
      exec_gate(GATE_SWAP,  8'd255, 8'd255, 8'd255); // swap a bit with itself
      exec_gate(GATE_CNOT,  8'd1,   8'd1,   8'd0);   // control equals target: clears it
      exec_gate(GATE_CCNOT, 8'd255, 8'd255, 8'd255); // all three operands the same bit
      send_undefined();
      restore_to(shadow_head);                   // rewind to where we already are
      take_checkpoint();
      restore_to(10'd3);                         // undo part of the log
      // Step back past entry zero into the never-written last entry; the counter wraps below zero.
      restore_to(POS_W'(LOG_DEPTH - 1));
      exec_gate(GATE_NOT, 8'd0, 8'd255, 8'd255); // head wraps forward to zero
      restore_to(10'd0);
      take_checkpoint();
   endtask

   // Mostly well-formed undo sessions: checkpoint, a few gates, then rewind or keep.
   // The rest is loose gates, stray checkpoints, undefined requests and no-op or random rewinds.
   task automatic test_random_sessions(input int quota);
      int               stop_at;
      int               roll;
      int               n;
      logic [POS_W-1:0] marks [$];
      stop_at = requests_sent + quota;
      while (requests_sent < stop_at) begin
         roll = $urandom_range(0, 99);
         if (roll < 70) begin
            take_checkpoint();
            marks.push_back(shadow_head);
            if (marks.size() > 16) void'(marks.pop_front());
            n = $urandom_range(1, 12);
            repeat (n) exec_random_gate();
            roll = $urandom_range(0, 99);
            if (roll < 50) begin
               restore_to(marks.pop_back());
            end else if (roll < 65) begin
               // unwind one or more nested sessions at once
               n = $urandom_range(0, marks.size() - 1);
               while (marks.size() > n + 1) void'(marks.pop_back());
               restore_to(marks.pop_back());
            end
         end else if (roll < 85) begin
            exec_random_gate();
         end else if (roll < 90) begin
            take_checkpoint();
         end else if (roll < 94) begin
            send_undefined();
         end else if (roll < 98) begin
            restore_to(shadow_head);
         end else if ($urandom_range(0, 9) == 0) begin
            // rare rewind to anywhere; the saved marks mean nothing afterward
            restore_to(POS_W'($urandom));
            marks.delete();
         end else begin
            exec_random_gate();
         end
      end
   endtask

   // A long stretch with neither side idling.
   task automatic test_back_to_back();
      idle_enable = 1'b0;
      test_random_sessions(150);
      idle_enable = 1'b1;
   endtask

   // Long walks through the log, including a full lap and the position extremes.
   task automatic test_long_rewind();
      repeat (20) exec_random_gate();
      restore_to(shadow_head + 1'b1);
      restore_to(POS_W'(LOG_DEPTH - 1));
      restore_to('0);
      restore_to(10'h2AA);
      restore_to(10'h155);
      restore_to(POS_W'($urandom));
   endtask

   initial begin
      reset_shadow();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // the block clears its memories after reset; the first send waits on the handshake
      test_directed_cases();
      test_random_sessions(500);
      test_back_to_back();
      test_long_rewind();
      test_random_sessions(430);

      // let the last results drain, then watch a while for strays
      wait_for_results();
      repeat (40) @(posedge clock);

      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // this ends a hung run
   initial begin
      #5ms;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

FILE: files.f
hdl/rge_pkg.sv
hdl/rge_bit_ram.sv
hdl/rge_log_ram.sv
hdl/rge_gate_alu.sv
hdl/reversible_gate_engine_with_undo_log.sv
hdl/rge_checker.sv
dv/testbench.sv
